### rtl/pese_pkg.sv
// Shared types and codes for the prefix expression stack evaluator.
package pese_pkg;

    localparam int unsigned DATA_W = 32;

    localparam logic [1:0] MODE_PUSH = 2'd0;
    localparam logic [1:0] MODE_BIN  = 2'd1;
    localparam logic [1:0] MODE_NOT  = 2'd2;
    localparam logic [1:0] MODE_NEG  = 2'd3;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_DIV = 4'd2;
    localparam logic [3:0] OP_MUL = 4'd3;
    localparam logic [3:0] OP_EQ  = 4'd4;
    localparam logic [3:0] OP_LT  = 4'd5;
    localparam logic [3:0] OP_GT  = 4'd6;
    localparam logic [3:0] OP_GE  = 4'd7;
    localparam logic [3:0] OP_LE  = 4'd8;
    localparam logic [3:0] OP_NE  = 4'd9;
    localparam logic [3:0] OP_AND = 4'd10;
    localparam logic [3:0] OP_OR  = 4'd11;
    localparam logic [3:0] OP_MOD = 4'd12;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_DIV0  = 2'd1;
    localparam logic [1:0] ERR_UNDER = 2'd2;
    localparam logic [1:0] ERR_OVER  = 2'd3;

    typedef struct packed {
        logic [1:0]               mode;
        logic [3:0]               op_code;
        logic signed [DATA_W-1:0] literal;
        logic                     last;
    } tok_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic [1:0]               status;
    } res_item_t;

endpackage

### rtl/prefix_expression_stack_evaluator_core.sv
// Prefix expression evaluator on a signed 32-bit operand stack with a RAM backing store.
//
// The block takes the tokens of a prefix expression in reverse order, one token per
// item, and evaluates them on an operand stack of STACK_DEPTH entries. The two top
// entries live in registers and everything below them lives in a synchronous RAM
// with one write port and one registered read port; the RAM is never cleared, since
// only entries below the stack count are ever read. A push, a logical not, a negate
// and every binary operator except divide and modulo are done in the cycle that
// accepts them. A binary operator that finds three or more entries on the stack
// and directly follows another accepted item is held while the RAM read of the
// third entry completes. Divide and modulo with a nonzero divisor run on a one-bit-
// per-cycle restoring divider: 32 divide steps, then a step that signs the result;
// no new item is taken meanwhile. The first error since the last clear is kept:
// underflow reads missing operands as zero, overflow drops the push, and a zero
// divisor yields zero. On an item marked last the block emits the new top of the
// stack with the status, then clears the stack and the error. A result waits in an
// output register; a new item is accepted in the cycle the waiting result leaves.
module prefix_expression_stack_evaluator_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tok_valid,
    output logic                tok_stall,
    input  pese_pkg::tok_item_t tok,
    output logic                res_valid,
    input  logic                res_stall,
    output pese_pkg::res_item_t res
);

    import pese_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [DATA_W-1:0] sec_reg, sec_next;
    logic [1:0]        err_reg, err_next;
    logic              rd_ok_reg;

    // Divider state.
    logic [DATA_W-1:0] dvd_reg, dvd_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [4:0]        iter_reg, iter_next;
    logic              neg_reg, neg_next;
    logic              is_mod_reg, is_mod_next;
    logic              last_pend_reg, last_pend_next;
    logic [1:0]        status_pend_reg, status_pend_next;

    // Output register.
    logic              res_valid_reg, res_valid_next;
    res_item_t         res_reg, res_next;

    // RAM ports.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic              tok_accept;
    logic              res_free;
    logic [DATA_W-1:0] a_val;
    logic [DATA_W-1:0] b_val;
    logic [DATA_W-1:0] op_res;
    logic [1:0]        err_new;
    logic              div_start;
    logic              is_div_op;
    logic [DATA_W:0]   rem_shift;
    logic [DATA_W:0]   rem_diff;
    logic [DATA_W-1:0] div_mag;
    logic [DATA_W-1:0] div_res;

    function automatic logic [DATA_W-1:0] alu(input logic [3:0] op,
                                              input logic [DATA_W-1:0] a,
                                              input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] r;
        r = '0;
        case (op)
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_MUL:  r = a * b;
            OP_EQ:   r = {{(DATA_W-1){1'b0}}, a == b};
            OP_LT:   r = {{(DATA_W-1){1'b0}}, $signed(a) < $signed(b)};
            OP_GT:   r = {{(DATA_W-1){1'b0}}, $signed(a) > $signed(b)};
            OP_GE:   r = {{(DATA_W-1){1'b0}}, $signed(a) >= $signed(b)};
            OP_LE:   r = {{(DATA_W-1){1'b0}}, $signed(a) <= $signed(b)};
            OP_NE:   r = {{(DATA_W-1){1'b0}}, a != b};
            OP_AND:  r = {{(DATA_W-1){1'b0}}, (a != '0) && (b != '0)};
            OP_OR:   r = {{(DATA_W-1){1'b0}}, (a != '0) || (b != '0)};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    // The third entry from the top sits at count - 3; it is read every cycle so that
    // a binary operator can refill the second register from it.
    assign ram_raddr = AW'(count_reg - CW'(3));
    assign ram_waddr = AW'(count_reg - CW'(2));

    pese_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sec_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_free  = !res_valid_reg || !res_stall;
    assign tok_stall = (state_reg != ST_IDLE) || !res_free ||
                       ((tok.mode == MODE_BIN) && (count_reg >= CW'(3)) && !rd_ok_reg);
    assign tok_accept = tok_valid && !tok_stall;

    assign a_val     = (count_reg >= CW'(1)) ? top_reg : '0;
    assign b_val     = (count_reg >= CW'(2)) ? sec_reg : '0;
    assign op_res    = alu(tok.op_code, a_val, b_val);
    assign is_div_op = (tok.op_code == OP_DIV) || (tok.op_code == OP_MOD);

    // One restoring divide step on magnitudes.
    assign rem_shift = {rem_reg, dvd_reg[DATA_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign div_mag   = is_mod_reg ? rem_reg : dvd_reg;
    assign div_res   = neg_reg ? (~div_mag + 1'b1) : div_mag;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        top_next         = top_reg;
        sec_next         = sec_reg;
        err_next         = err_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        dvs_next         = dvs_reg;
        iter_next        = iter_reg;
        neg_next         = neg_reg;
        is_mod_next      = is_mod_reg;
        last_pend_next   = last_pend_reg;
        status_pend_next = status_pend_reg;
        res_valid_next   = res_valid_reg && res_stall;
        res_next         = res_reg;
        ram_we           = 1'b0;
        err_new          = ERR_NONE;
        div_start        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (tok_accept)
                begin
                    case (tok.mode)
                        MODE_PUSH:
                        begin
                            if (count_reg == CW'(STACK_DEPTH))
                            begin
                                err_new = ERR_OVER;
                            end
                            else
                            begin
                                // Spill the second entry to RAM when it goes third.
                                ram_we     = (count_reg >= CW'(2));
                                sec_next   = top_reg;
                                top_next   = tok.literal;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        MODE_BIN:
                        begin
                            if (count_reg < CW'(2))
                            begin
                                err_new = ERR_UNDER;
                            end
                            else if (is_div_op && (b_val == '0))
                            begin
                                err_new = ERR_DIV0;
                            end
                            count_next = (count_reg <= CW'(1)) ? CW'(1) : count_reg - CW'(1);
                            sec_next   = ram_rdata;
                            if (is_div_op && (b_val != '0))
                            begin
                                div_start = 1'b1;
                            end
                            else
                            begin
                                top_next = op_res;
                            end
                        end
                        MODE_NOT:
                        begin
                            if (count_reg == '0)
                            begin
                                err_new = ERR_UNDER;
                            end
                            count_next = (count_reg == '0) ? CW'(1) : count_reg;
                            top_next   = {{(DATA_W-1){1'b0}}, a_val == '0};
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                err_new = ERR_UNDER;
                            end
                            count_next = (count_reg == '0) ? CW'(1) : count_reg;
                            top_next   = ~a_val + 1'b1;
                        end
                    endcase

                    err_next = (err_reg != ERR_NONE) ? err_reg : err_new;

                    if (div_start)
                    begin
                        dvd_next         = mag(a_val);
                        dvs_next         = mag(b_val);
                        rem_next         = '0;
                        iter_next        = '0;
                        is_mod_next      = (tok.op_code == OP_MOD);
                        neg_next         = (tok.op_code == OP_MOD) ? a_val[DATA_W-1] :
                                           (a_val[DATA_W-1] ^ b_val[DATA_W-1]);
                        last_pend_next   = tok.last;
                        status_pend_next = err_next;
                        state_next       = ST_DIV;
                    end
                    else if (tok.last)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '{result: top_next, status: err_next};
                    end

                    if (tok.last)
                    begin
                        count_next = '0;
                        err_next   = ERR_NONE;
                    end
                end
            end
            ST_DIV:
            begin
                if (!rem_diff[DATA_W])
                begin
                    rem_next = rem_diff[DATA_W-1:0];
                    dvd_next = {dvd_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[DATA_W-1:0];
                    dvd_next = {dvd_reg[DATA_W-2:0], 1'b0};
                end
                iter_next = iter_reg + 5'd1;
                if (iter_reg == 5'd31)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!last_pend_reg || res_free)
                begin
                    top_next   = div_res;
                    state_next = ST_IDLE;
                    if (last_pend_reg)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = '{result: div_res, status: status_pend_reg};
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            err_reg       <= ERR_NONE;
            rd_ok_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            err_reg       <= err_next;
            // The flag marks that no item was accepted at the last clock edge, so the read
            // data matches the current count.
            rd_ok_reg     <= !tok_accept;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg         <= top_next;
        sec_reg         <= sec_next;
        dvd_reg         <= dvd_next;
        rem_reg         <= rem_next;
        dvs_reg         <= dvs_next;
        iter_reg        <= iter_next;
        neg_reg         <= neg_next;
        is_mod_reg      <= is_mod_next;
        last_pend_reg   <= last_pend_next;
        status_pend_reg <= status_pend_next;
        res_reg         <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // The stack count never passes the depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    // A last item clears the stack and the error.
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_accept && tok.last) |=> (count_reg == '0) && (err_reg == ERR_NONE))
        else $error("stack not cleared after last item");

    // A recorded error is kept until a last item clears it.
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ((err_reg != ERR_NONE) && !tok_accept) |=> (err_reg == $past(err_reg)))
        else $error("error code changed without an item");

    // A last item that needs no divide shows its result in the next cycle.
    a_last_result: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_accept && tok.last && !div_start) |=> res_valid_reg)
        else $error("result missing after last item");

    // The divider always completes its 32 steps.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && (iter_reg == 5'd31)) |=> (state_reg == ST_DONE))
        else $error("divider did not finish");

endmodule

### rtl/pese_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pese_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### bench/stack_eval_checker.sv
// Scoreboard that tracks the operand stack from the token stream and checks each emitted result.
module stack_eval_checker #(
    parameter int STACK_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tok_valid,
    input  logic                tok_stall,
    input  pese_pkg::tok_item_t tok,
    input  logic                res_valid,
    input  logic                res_stall,
    input  pese_pkg::res_item_t res,
    output int                  errors,
    output int                  outstanding
);
    import pese_pkg::*;

    logic [DATA_W-1:0] operands [STACK_DEPTH];
    int                stack_fill;
    logic [1:0]        err_code;
    res_item_t         result_q [$];

    // Only the first error since the last clear is kept.
    function automatic void note_error(logic [1:0] code);
        if (err_code == ERR_NONE)
            err_code = code;
    endfunction

    function automatic logic [DATA_W-1:0] pop_operand();
        if (stack_fill == 0)
        begin
            note_error(ERR_UNDER);
            return '0;
        end
        stack_fill--;
        return operands[stack_fill];
    endfunction

    function automatic void push_operand(logic [DATA_W-1:0] v);
        if (stack_fill >= STACK_DEPTH)
        begin
            note_error(ERR_OVER);
            return;
        end
        operands[stack_fill] = v;
        stack_fill++;
    endfunction

    function automatic logic [DATA_W-1:0] abs_val(logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? -v : v;
    endfunction

    // The left operand a is the top of the stack, b the entry below it.
    function automatic logic [DATA_W-1:0] combine(logic [3:0] op, logic [DATA_W-1:0] a,
                                                  logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] q;
        case (op)
            OP_ADD: return a + b;
            OP_SUB: return a - b;
            OP_DIV:
            begin
                if (b == '0)
                begin
                    note_error(ERR_DIV0);
                    return '0;
                end
                q = abs_val(a) / abs_val(b);
                return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
            end
            OP_MUL: return a * b;
            OP_EQ:  return DATA_W'(a == b);
            OP_LT:  return DATA_W'($signed(a) < $signed(b));
            OP_GT:  return DATA_W'($signed(a) > $signed(b));
            OP_GE:  return DATA_W'($signed(a) >= $signed(b));
            OP_LE:  return DATA_W'($signed(a) <= $signed(b));
            OP_NE:  return DATA_W'(a != b);
            OP_AND: return DATA_W'((a != '0) && (b != '0));
            OP_OR:  return DATA_W'((a != '0) || (b != '0));
            OP_MOD:
            begin
                if (b == '0)
                begin
                    note_error(ERR_DIV0);
                    return '0;
                end
                q = abs_val(a) % abs_val(b);
                return a[DATA_W-1] ? -q : q;
            end
            default: return '0;
        endcase
    endfunction

    function automatic void apply_token(tok_item_t t);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        res_item_t         r;
        case (t.mode)
            MODE_PUSH: push_operand(t.literal);
            MODE_BIN:
            begin
                a = pop_operand();
                b = pop_operand();
                push_operand(combine(t.op_code, a, b));
            end
            MODE_NOT:
            begin
                a = pop_operand();
                push_operand(DATA_W'(a == '0));
            end
            default:
            begin
                a = pop_operand();
                push_operand(-a);
            end
        endcase
        if (t.last)
        begin
            r.result = pop_operand();
            r.status = err_code;
            result_q = {result_q, r};
            stack_fill = 0;
            err_code = ERR_NONE;
        end
    endfunction

    function automatic void check_result(res_item_t got);
        res_item_t want;
        if (result_q.size() == 0)
        begin
            $display("%0t: unexpected result: expected none, actual result %0d status %0d",
                     $time, got.result, got.status);
            errors++;
            return;
        end
        want = result_q.pop_front();
        if (got.result !== want.result)
        begin
            $display("%0t: result mismatch: expected %0d, actual %0d",
                     $time, want.result, got.result);
            errors++;
        end
        if (got.status !== want.status)
        begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_fill = 0;
            err_code = ERR_NONE;
            result_q.delete();
            errors = 0;
            outstanding = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
                check_result(res);
            if (tok_valid && !tok_stall)
                apply_token(tok);
            outstanding = result_q.size();
        end
    end

endmodule

### bench/tb.sv
// Top of the testbench: clock, reset, token stimulus, result back-pressure and the verdict.
module tb;
    import pese_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1000;
    localparam int CYCLE_LIMIT  = 600000;
    // Long enough for a full divide to finish after the last token.
    localparam int TAIL_CYCLES  = 80;

    localparam logic [3:0]        OP_UNDEF = 4'd15;
    localparam logic [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [DATA_W-1:0] MOST_POS = 32'h7fff_ffff;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      tok_valid = 1'b0;
    logic      tok_stall;
    tok_item_t tok       = '0;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_item_t res;

    int errors;
    int outstanding;
    int cycle_count = 0;
    int items_sent  = 0;
    int directed_count;
    bit quiet       = 1'b0;
    bit mid_drained = 1'b0;
    int pick;

    prefix_expression_stack_evaluator_core #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .tok_valid(tok_valid),
        .tok_stall(tok_stall),
        .tok      (tok),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .res      (res)
    );

    stack_eval_checker #(
        .STACK_DEPTH(DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .tok_valid  (tok_valid),
        .tok_stall  (tok_stall),
        .tok        (tok),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res),
        .errors     (errors),
        .outstanding(outstanding)
    );

    always #10 clk = ~clk;

    // The run is cut off at the cycle limit, which catches a block that stops making progress.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Literals lean on the extremes and on small values, so that zero divisors and
    // sign corner cases come up often.
    function automatic logic [DATA_W-1:0] pick_literal();
        int r;
        int near;
        r = $urandom_range(0, 99);
        if (r < 8)
            return MOST_NEG;
        if (r < 16)
            return MOST_POS;
        if (r < 24)
            return '1;
        if (r < 34)
            return '0;
        if (r < 70)
        begin
            near = int'($urandom_range(0, 40)) - 20;
            return DATA_W'(near);
        end
        return $urandom;
    endfunction

    function automatic tok_item_t make_tok(logic [1:0] mode, logic [3:0] op,
                                           logic [DATA_W-1:0] lit, logic is_last);
        tok_item_t t;
        t.mode    = mode;
        t.op_code = op;
        t.literal = lit;
        t.last    = is_last;
        return t;
    endfunction

    function automatic tok_item_t push_tok(logic is_last);
        return make_tok(MODE_PUSH, 4'($urandom_range(0, 15)), pick_literal(), is_last);
    endfunction

    function automatic tok_item_t binary_tok(logic is_last);
        return make_tok(MODE_BIN, 4'($urandom_range(OP_ADD, OP_MOD)), $urandom, is_last);
    endfunction

    function automatic tok_item_t unary_tok(logic is_last);
        return make_tok($urandom_range(0, 1) ? MODE_NOT : MODE_NEG,
                        4'($urandom_range(0, 15)), $urandom, is_last);
    endfunction

    // Offer one item and hold it until the block takes it. Valid stays high into the
    // next item when there is no gap.
    task automatic send(input tok_item_t t);
        int gap;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0)
        begin
            tok_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tok_valid <= 1'b1;
        tok       <= t;
        do
            @(posedge clk);
        while (tok_stall);
        items_sent++;
    endtask

    // Stop sending and wait until every expected result has come out.
    task automatic drain();
        tok_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // A well-formed expression: the stack never runs short and ends with one entry.
    // Deep expressions push harder so that they reach a full stack.
    task automatic send_expression();
        int target;
        int fill;
        int count;
        int cap;
        int bias;
        bit deep;
        deep   = ($urandom_range(0, 7) == 0);
        target = deep ? 40 : (($urandom_range(0, 9) == 0) ? $urandom_range(12, 24)
                                                          : $urandom_range(1, 10));
        cap    = deep ? DEPTH : $urandom_range(2, 6);
        bias   = deep ? 3 : 2;
        fill   = 0;
        count  = 0;
        forever
        begin
            if (count >= target)
            begin
                if (fill == 0)
                begin
                    send(push_tok(1'b1));
                    return;
                end
                if (fill == 1)
                begin
                    send(unary_tok(1'b1));
                    return;
                end
                if (fill == 2)
                begin
                    send(binary_tok(1'b1));
                    return;
                end
                send(binary_tok(1'b0));
                fill--;
            end
            else if (fill < 2 || (fill < cap && $urandom_range(0, 3) < bias))
            begin
                send(push_tok(1'b0));
                fill++;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                send(unary_tok(1'b0));
            end
            else
            begin
                send(binary_tok(1'b0));
                fill--;
            end
            count++;
        end
    endtask

    // Sequences that run the stack over or under, or use an undefined operator.
    task automatic send_broken();
        case ($urandom_range(0, 2))
            0:
            begin
                repeat ($urandom_range(DEPTH + 1, DEPTH + 3)) send(push_tok(1'b0));
                send($urandom_range(0, 1) ? binary_tok(1'b1) : push_tok(1'b1));
            end
            1:
            begin
                repeat ($urandom_range(0, 1)) send(push_tok(1'b0));
                repeat ($urandom_range(1, 3))
                    send($urandom_range(0, 1) ? binary_tok(1'b0) : unary_tok(1'b0));
                send(binary_tok(1'b1));
            end
            default:
            begin
                send(push_tok(1'b0));
                send(push_tok(1'b0));
                send(make_tok(MODE_BIN, 4'($urandom_range(OP_MOD + 1, OP_UNDEF)),
                              $urandom, 1'b0));
                send(unary_tok(1'b1));
            end
        endcase
    endtask

    // Back-pressure on the result side, in bursts of random length. During a quiet
    // stretch the receiver takes everything.
    initial
    begin
        @(posedge clk);
        forever
        begin
            res_stall <= 1'b0;
            repeat (quiet ? $urandom_range(20, 60) : pick_gap() + 1) @(posedge clk);
            if (!quiet)
            begin
                res_stall <= 1'b1;
                repeat (pick_gap() + 1) @(posedge clk);
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Most negative over minus one: the quotient wraps, the remainder is zero.
        send(make_tok(MODE_PUSH, OP_ADD, '1, 1'b0));
        send(make_tok(MODE_PUSH, OP_ADD, MOST_NEG, 1'b0));
        send(make_tok(MODE_BIN, OP_DIV, '0, 1'b1));
        send(make_tok(MODE_PUSH, OP_ADD, '1, 1'b0));
        send(make_tok(MODE_PUSH, OP_ADD, MOST_NEG, 1'b0));
        send(make_tok(MODE_BIN, OP_MOD, '0, 1'b1));
        // A zero divisor gives zero and the divide error.
        send(make_tok(MODE_PUSH, OP_ADD, '0, 1'b0));
        send(make_tok(MODE_PUSH, OP_ADD, MOST_POS, 1'b0));
        send(make_tok(MODE_BIN, OP_DIV, '0, 1'b1));
        // The remainder follows the sign of the dividend: -7 mod 3 is -1.
        send(make_tok(MODE_PUSH, OP_ADD, 32'd3, 1'b0));
        send(make_tok(MODE_PUSH, OP_ADD, -32'sd7, 1'b0));
        send(make_tok(MODE_BIN, OP_MOD, '0, 1'b1));
        // An operator on an empty stack reads zeros and flags underflow.
        send(make_tok(MODE_BIN, OP_ADD, MOST_POS, 1'b1));
        // Negating the most negative value wraps to itself.
        send(make_tok(MODE_PUSH, OP_ADD, MOST_NEG, 1'b0));
        send(make_tok(MODE_NEG, OP_ADD, '0, 1'b1));
        // Logical not of zero.
        send(make_tok(MODE_PUSH, OP_ADD, '0, 1'b0));
        send(make_tok(MODE_NOT, OP_ADD, '1, 1'b1));
        // An undefined operator pops both operands and pushes zero.
        send(make_tok(MODE_PUSH, OP_ADD, 32'd1, 1'b0));
        send(make_tok(MODE_PUSH, OP_ADD, 32'd2, 1'b0));
        send(make_tok(MODE_BIN, OP_UNDEF, '0, 1'b1));
        // The divide error comes first, so the later underflow must not replace it.
        send(make_tok(MODE_PUSH, OP_ADD, '0, 1'b0));
        send(make_tok(MODE_PUSH, OP_ADD, 32'd1, 1'b0));
        send(make_tok(MODE_BIN, OP_DIV, '0, 1'b0));
        send(make_tok(MODE_BIN, OP_SUB, '0, 1'b1));
        directed_count = items_sent;

        // The sender holds off here until the directed results are all back.
        drain();

        while (items_sent < directed_count + RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 6) == 0);
            pick  = $urandom_range(0, 99);
            if (pick < 78)
                send_expression();
            else if (pick < 90)
                send_broken();
            else
                send(make_tok(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
                              $urandom, ($urandom_range(0, 3) == 0)));
            if (!mid_drained && items_sent >= directed_count + RANDOM_ITEMS / 2)
            begin
                drain();
                mid_drained = 1'b1;
            end
        end
        quiet = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
